// ===== hdl/weighted_random_index_select_assert.svh =====
// assertion macros for the weighted random index select rtl
`ifndef WEIGHTED_RANDOM_INDEX_SELECT_ASSERT_SVH
`define WEIGHTED_RANDOM_INDEX_SELECT_ASSERT_SVH

// property checked on every rising edge outside reset
`define WRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define WRS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== hdl/wrs_pkg.sv =====
// types, constants and helpers shared by the weighted random index select
`timescale 1ns / 1ps
`default_nettype none

package wrs_pkg;

  localparam int unsigned WEIGHT_W = 32;
  localparam int unsigned RND_W    = 32;
  localparam int unsigned IDX_W    = 6;

  localparam logic [WEIGHT_W-1:0] MAX_WEIGHT_RST = 32'd10000;

  localparam logic KIND_APPEND = 1'b0;
  localparam logic KIND_SELECT = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [WEIGHT_W-1:0] weight;
    logic                available;
    logic [RND_W-1:0]    random_value;
  } wrs_in_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] selected_index;
    logic             overflow;
  } wrs_out_t;

  typedef struct packed {
    logic                available;
    logic [WEIGHT_W-1:0] weight;
  } wrs_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_MOD,
    ST_WALK,
    ST_DONE
  } wrs_state_e;

  // entry takes part when available and weight in 1..max
  function automatic logic entry_counts(wrs_entry_t e, logic [WEIGHT_W-1:0] max_w);
    entry_counts = e.available && (e.weight != '0) && (e.weight <= max_w);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/wrs_store.sv =====
// entry memory: one write port, one read port with registered data
`timescale 1ns / 1ps
`default_nettype none

module wrs_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic                clk_i,
  input  wire logic                wr_en_i,
  input  wire logic [AW-1:0]       wr_addr_i,
  input  wire wrs_pkg::wrs_entry_t wr_data_i,
  input  wire logic                rd_en_i,
  input  wire logic [AW-1:0]       rd_addr_i,
  output      wrs_pkg::wrs_entry_t rd_data_o
);
  import wrs_pkg::*;

  wrs_entry_t mem [DEPTH];
  wrs_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== hdl/wrs_mod.sv =====
// bit-serial restoring modulo, one dividend bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module wrs_mod #(
  parameter int unsigned TW = 38
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [wrs_pkg::RND_W-1:0] dividend_i,
  input  wire logic [TW-1:0]            divisor_i,
  output      logic                     done_o,
  output      logic [TW-1:0]            rem_o
);
  import wrs_pkg::*;

  localparam int unsigned CNT_W = $clog2(RND_W);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [RND_W-1:0] dvd_q;
  logic [TW-1:0]    div_q;
  logic [TW-1:0]    rem_q;
  logic [TW:0]      rem_sh;
  logic [TW:0]      rem_sub;
  logic             last_step;

  assign rem_sh    = {rem_q, dvd_q[RND_W-1]};
  assign rem_sub   = rem_sh - {1'b0, div_q};
  assign last_step = busy_q && (cnt_q == CNT_W'(RND_W - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= last_step;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (last_step) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      cnt_q <= '0;
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      dvd_q <= {dvd_q[RND_W-2:0], 1'b0};
      // trial subtract, keep the shifted remainder when it goes negative
      if (rem_sh >= {1'b0, div_q}) begin
        rem_q <= rem_sub[TW-1:0];
      end else begin
        rem_q <= rem_sh[TW-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

`include "weighted_random_index_select_assert.svh"

  `WRS_ASSERT(a_rem_below_div, done_o |-> (rem_o < div_q), "remainder not below divisor")
  `WRS_ASSERT_NEVER(a_start_busy, start_i && busy_q, "modulo restarted while running")
  `WRS_ASSERT(a_done_single, done_o |=> !done_o, "done held longer than one cycle")
  `WRS_ASSERT(a_done_idle, done_o |-> (!busy_q && $past(busy_q)), "done without a finished run")

endmodule

`default_nettype wire

// ===== hdl/weighted_random_index_select.sv =====
// top level of the weighted random index select (roulette wheel)
`timescale 1ns / 1ps
`default_nettype none

// Weighted random index select. Append requests (kind 0) store one entry of
// weight and availability each; entries beyond MAX_ENTRIES are dropped and
// flagged as overflow in the next result. A select request (kind 1) runs
// three passes: a sum over the n stored entries through the single read
// port of the entry memory, a bit-serial modulo of the random value by that
// sum, and a walk that reads entries again and subtracts weights until the
// remainder falls inside one; then it loads the result register. The modulo
// and the walk are skipped when no entry counts. An entry counts when
// available and its weight lies in 1..max_weight, using max_weight as it
// stands at the select. Every select empties the list and clears the
// overflow flag. The max_weight register (reset 10000) is written through
// the cfg channel, always ready; write it only while the block is idle.
module weighted_random_index_select #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output      logic                            in_ready_o,
  input  wire wrs_pkg::wrs_in_t                in_data_i,
  output      logic                            out_valid_o,
  input  wire logic                            out_ready_i,
  output      wrs_pkg::wrs_out_t               out_data_o,
  input  wire logic                            cfg_valid_i,
  output      logic                            cfg_ready_o,
  input  wire logic [wrs_pkg::WEIGHT_W-1:0]    cfg_data_i
);
  import wrs_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  // total of up to MAX_ENTRIES weights
  localparam int unsigned TW = WEIGHT_W + $clog2(MAX_ENTRIES);

  wrs_state_e state_q, state_d;

  // control state
  logic [CW-1:0]       cnt_q;
  logic                ovf_q;
  logic [WEIGHT_W-1:0] maxw_q;
  logic                rd_vld_q;
  logic                out_valid_q;

  // payload
  logic [RND_W-1:0] rnd_q;
  logic [TW-1:0]    sum_q;
  logic [RND_W-1:0] roll_q;
  logic [CW-1:0]    ptr_q;
  logic [AW-1:0]    rd_idx_q;
  logic             found_q;
  logic [AW-1:0]    hit_idx_q;
  wrs_out_t         out_q;

  logic       in_fire;
  logic       is_append;
  logic       is_select;
  logic       has_room;
  logic       rd_issue;
  logic       rd_counts;
  logic       sum_done;
  logic       walk_hit;
  logic       walk_end;
  logic       out_free;
  logic       mod_start;
  logic       mod_done;
  logic [TW-1:0] mod_rem;
  wrs_entry_t wr_entry;
  wrs_entry_t rd_entry;

  assign in_fire   = in_valid_i && in_ready_o;
  assign is_append = in_fire && (in_data_i.kind == KIND_APPEND);
  assign is_select = in_fire && (in_data_i.kind == KIND_SELECT);
  assign has_room  = cnt_q < CW'(MAX_ENTRIES);
  assign out_free  = !out_valid_q || out_ready_i;

  assign wr_entry.available = in_data_i.available;
  assign wr_entry.weight    = in_data_i.weight;

  // one memory read a cycle in both passes, read data arrives in the next cycle
  assign rd_counts = entry_counts(rd_entry, maxw_q);
  assign sum_done  = (state_q == ST_SUM) && !rd_issue && !rd_vld_q;
  assign walk_hit  = (state_q == ST_WALK) && rd_vld_q && rd_counts &&
                     (roll_q < rd_entry.weight);
  assign walk_end  = (state_q == ST_WALK) && !rd_issue && !rd_vld_q;

  wrs_store #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (is_append && has_room),
    .wr_addr_i (cnt_q[AW-1:0]),
    .wr_data_i (wr_entry),
    .rd_en_i   (rd_issue),
    .rd_addr_i (ptr_q[AW-1:0]),
    .rd_data_o (rd_entry)
  );

  wrs_mod #(
    .TW (TW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (rnd_q),
    .divisor_i  (sum_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (is_select) state_d = ST_SUM;
      end
      ST_SUM: begin
        if (sum_done) state_d = (sum_q != '0) ? ST_MOD : ST_DONE;
      end
      ST_MOD: begin
        if (mod_done) state_d = ST_WALK;
      end
      ST_WALK: begin
        if (walk_hit || walk_end) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_o = 1'b0;
    rd_issue   = 1'b0;
    mod_start  = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_SUM: begin
        rd_issue  = ptr_q < cnt_q;
        mod_start = sum_done && (sum_q != '0);
      end
      ST_WALK: rd_issue = ptr_q < cnt_q;
      ST_MOD, ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      maxw_q      <= MAX_WEIGHT_RST;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_issue;
      if (cfg_valid_i) begin
        maxw_q <= cfg_data_i;
      end
      if (is_append) begin
        if (has_room) begin
          cnt_q <= cnt_q + 1'b1;
        end else begin
          ovf_q <= 1'b1;
        end
      end
      // result loads once the output register is free, list empties
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
        cnt_q       <= '0;
        ovf_q       <= 1'b0;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_issue) begin
      ptr_q    <= ptr_q + 1'b1;
      rd_idx_q <= ptr_q[AW-1:0];
    end
    unique case (state_q)
      ST_IDLE: begin
        if (is_select) begin
          rnd_q   <= in_data_i.random_value;
          sum_q   <= '0;
          ptr_q   <= '0;
          found_q <= 1'b0;
        end
      end
      ST_SUM: begin
        if (rd_vld_q && rd_counts) begin
          sum_q <= sum_q + TW'(rd_entry.weight);
        end
      end
      ST_MOD: begin
        ptr_q <= '0;
        if (mod_done) begin
          roll_q <= mod_rem[RND_W-1:0];
        end
      end
      ST_WALK: begin
        if (walk_hit) begin
          found_q   <= 1'b1;
          hit_idx_q <= rd_idx_q;
        end else if (rd_vld_q && rd_counts) begin
          roll_q <= roll_q - rd_entry.weight;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_q.found          <= found_q;
          out_q.selected_index <= found_q ? IDX_W'(hit_idx_q) : '0;
          out_q.overflow       <= ovf_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

endmodule

`default_nettype wire

// ===== verif/weighted_random_index_select_tb.sv =====
// self-checking testbench for the weighted random index select
`timescale 1ns / 1ps

module weighted_random_index_select_tb;
  import wrs_pkg::*;

  localparam int unsigned ENTRIES          = 64;
  localparam int unsigned QUIET_LIMIT      = 2000;  // longest select plus stalls, many times over
  localparam int unsigned SETTLE_CYCLES    = 16;
  localparam int unsigned DRAIN_CYCLES     = 200;
  localparam int unsigned PHASES           = 7;
  localparam int unsigned ITEMS_PER_PHASE  = 90;
  localparam int unsigned SHOWN_MISMATCHES = 10;

  // one row of the directed table, want only meaningful when typed is set
  typedef struct packed {
    wrs_in_t  req;
    logic     typed;
    wrs_out_t want;
  } dir_row_t;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  wrs_in_t             in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  wrs_out_t            out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [WEIGHT_W-1:0] cfg_data  = '0;

  // hand-typed expectation travelling with the request it belongs to
  logic                req_typed = 1'b0;
  wrs_out_t            req_want  = '0;

  // mirror of the entry list and the max weight register
  logic [WEIGHT_W-1:0] held_weight [ENTRIES];
  logic                held_avail  [ENTRIES];
  int unsigned         held_count   = 0;
  logic                held_dropped = 1'b0;
  logic [WEIGHT_W-1:0] live_max     = MAX_WEIGHT_RST;
  wrs_out_t            pending_picks [$];

  // directed stimulus table
  dir_row_t            rows [$];

  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;

  // idling knobs, changed per phase
  int unsigned gap_max    = 0;
  int unsigned stall_max  = 0;
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;

  weighted_random_index_select #(
    .MAX_ENTRIES(ENTRIES)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // an entry takes part when available and its weight lies in 1..lim
  function automatic logic weighs_in(input logic [WEIGHT_W-1:0] w, input logic a,
                                     input logic [WEIGHT_W-1:0] lim);
    return a && (w != '0) && (w <= lim);
  endfunction

  // roulette wheel behaviour: appends fill the list, a select spins and empties it
  task automatic wheel_step(input wrs_in_t r, input logic typed, input wrs_out_t want);
    logic [37:0] total;
    logic [37:0] roll;
    logic        hit;
    wrs_out_t    pick;
    int unsigned i;
    total = '0;
    roll  = '0;
    hit   = 1'b0;
    pick  = '0;
    if (r.kind == KIND_APPEND) begin
      if (held_count < ENTRIES) begin
        held_weight[held_count] = r.weight;
        held_avail[held_count]  = r.available;
        held_count++;
      end else begin
        held_dropped = 1'b1;  // list full, entry lost
      end
    end else begin
      // total is taken with the max weight as it stands now, not at load time
      for (i = 0; i < held_count; i++) begin
        if (weighs_in(held_weight[i], held_avail[i], live_max)) begin
          total = total + {6'd0, held_weight[i]};
        end
      end
      if (total != '0) begin
        roll = {6'd0, r.random_value} % total;
        for (i = 0; i < held_count && !hit; i++) begin
          if (weighs_in(held_weight[i], held_avail[i], live_max)) begin
            if (roll < {6'd0, held_weight[i]}) begin
              hit = 1'b1;
              pick.selected_index = IDX_W'(i);
            end else begin
              roll = roll - {6'd0, held_weight[i]};
            end
          end
        end
      end
      pick.found    = hit;
      pick.overflow = held_dropped;
      pending_picks.insert(pending_picks.size(), typed ? want : pick);
      held_count   = 0;
      held_dropped = 1'b0;
    end
  endtask

  task automatic note_fail(input string msg);
    mismatches++;
    if (mismatches <= SHOWN_MISMATCHES) begin
      $display("%0t ns: %s", $time, msg);
    end
  endtask

  // sample every handshake at the rising edge, check results, then predict
  always @(posedge clk_i) begin : check_and_predict
    wrs_out_t exp_pick;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (pending_picks.size() == 0) begin
          note_fail($sformatf("unexpected result: found %0b index %0d overflow %0b",
                              out_data.found, out_data.selected_index, out_data.overflow));
        end else begin
          exp_pick = pending_picks.pop_front();
          if (out_data.found !== exp_pick.found ||
              out_data.selected_index !== exp_pick.selected_index ||
              out_data.overflow !== exp_pick.overflow) begin
            note_fail($sformatf({"result mismatch: expected found %0b index %0d overflow %0b,",
                                 " got found %0b index %0d overflow %0b"},
                                exp_pick.found, exp_pick.selected_index, exp_pick.overflow,
                                out_data.found, out_data.selected_index, out_data.overflow));
          end
        end
      end
      if (in_valid && in_ready) begin
        wheel_step(in_data, req_typed, req_want);
      end
      if (cfg_valid && cfg_ready) begin
        live_max = cfg_data;
      end
      if ((out_valid && out_ready) || (in_valid && in_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
  end

  // result side: ready most of the time, random stalls bounded by stall_max
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (stall_max != 0 && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, stall_max);
      end
    end
  end

  // nothing accepted for too long
  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  function automatic wrs_in_t append_req(input logic [WEIGHT_W-1:0] w, input logic a);
    wrs_in_t r;
    r.kind         = KIND_APPEND;
    r.weight       = w;
    r.available    = a;
    r.random_value = $urandom;  // ignored on appends
    return r;
  endfunction

  function automatic wrs_in_t select_req(input logic [RND_W-1:0] rnd);
    wrs_in_t r;
    r.kind         = KIND_SELECT;
    r.weight       = $urandom;  // ignored on selects
    r.available    = 1'($urandom);
    r.random_value = rnd;
    return r;
  endfunction

  function automatic wrs_out_t pick_of(input logic f, input logic [IDX_W-1:0] idx,
                                       input logic ovf);
    wrs_out_t o;
    o.found          = f;
    o.selected_index = idx;
    o.overflow       = ovf;
    return o;
  endfunction

  // append one row to the directed table
  task automatic add_row(input wrs_in_t req, input logic typed, input wrs_out_t want);
    dir_row_t row;
    row.req   = req;
    row.typed = typed;
    row.want  = want;
    rows.insert(rows.size(), row);
  endtask

  // weights cluster round the limit, zero and small values, with some wide ones
  function automatic logic [WEIGHT_W-1:0] draw_weight(input logic [WEIGHT_W-1:0] lim);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return lim;
      2: return lim + 1'b1;
      3: return lim - 1'b1;
      4: return $urandom;
      5: return $urandom >> $urandom_range(0, 31);
      6: return (lim > 1) ? $urandom_range(1, lim) : 32'd1;
      default: return $urandom_range(1, 20);
    endcase
  endfunction

  // sender works in bursts; a gap lowers valid only between requests
  task automatic push_request(input wrs_in_t r, input logic typed, input wrs_out_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid  <= 1'b1;
    in_data   <= r;
    req_typed <= typed;
    req_want  <= want;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic write_max_weight(input logic [WEIGHT_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // first edge lets the checker take in the request accepted at the current one
  task automatic wait_for_picks();
    do @(posedge clk_i); while (pending_picks.size() != 0);
  endtask

  initial begin : stimulus
    logic [WEIGHT_W-1:0] drive_max;
    int unsigned         p;
    int unsigned         k;
    int unsigned         sent;
    int unsigned         seqs;
    int unsigned         seq_len;
    wrs_in_t             r;

    drive_max = MAX_WEIGHT_RST;

    // directed rows, expectations worked out for the reset max weight of 10000
    add_row(select_req(32'd0), 1'b1, pick_of(1'b0, 6'd0, 1'b0));  // empty after reset
    add_row(append_req(32'd1, 1'b1), 1'b0, pick_of(1'b0, 6'd0, 1'b0));
    add_row(select_req('1), 1'b1, pick_of(1'b1, 6'd0, 1'b0));     // lone entry always wins
    add_row(append_req(32'd0, 1'b1), 1'b0, pick_of(1'b0, 6'd0, 1'b0));
    add_row(append_req(32'd10001, 1'b1), 1'b0, pick_of(1'b0, 6'd0, 1'b0));
    add_row(append_req('1, 1'b1), 1'b0, pick_of(1'b0, 6'd0, 1'b0));
    add_row(append_req(32'd5, 1'b0), 1'b0, pick_of(1'b0, 6'd0, 1'b0));
    add_row(select_req(32'd3), 1'b1, pick_of(1'b0, 6'd0, 1'b0));  // every entry excluded
    add_row(append_req(32'd0, 1'b0), 1'b0, pick_of(1'b0, 6'd0, 1'b0));
    add_row(append_req(32'd10000, 1'b1), 1'b0, pick_of(1'b0, 6'd0, 1'b0));
    add_row(append_req(32'd7, 1'b1), 1'b0, pick_of(1'b0, 6'd0, 1'b0));
    // 10000 mod 10007 runs past the heavy entry into the last one
    add_row(select_req(32'd10000), 1'b1, pick_of(1'b1, 6'd2, 1'b0));
    add_row(append_req(32'd3, 1'b1), 1'b0, pick_of(1'b0, 6'd0, 1'b0));
    add_row(append_req(32'd9999, 1'b1), 1'b0, pick_of(1'b0, 6'd0, 1'b0));
    add_row(append_req(32'd1, 1'b0), 1'b0, pick_of(1'b0, 6'd0, 1'b0));
    add_row(append_req(32'd2, 1'b1), 1'b0, pick_of(1'b0, 6'd0, 1'b0));
    add_row(select_req('1), 1'b0, pick_of(1'b0, 6'd0, 1'b0));
    add_row(select_req(32'h8000_0000), 1'b1, pick_of(1'b0, 6'd0, 1'b0));  // list emptied
    add_row(append_req(32'd10000, 1'b1), 1'b0, pick_of(1'b0, 6'd0, 1'b0));
    add_row(select_req(32'd0), 1'b1, pick_of(1'b1, 6'd0, 1'b0));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    gap_max   = 2;
    stall_max = 4;
    for (k = 0; k < rows.size(); k++) begin
      push_request(rows[k].req, rows[k].typed, rows[k].want);
    end

    for (p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        // register only written once the block has gone quiet
        in_valid <= 1'b0;
        wait_for_picks();
        repeat (SETTLE_CYCLES) @(posedge clk_i);
        case (p)
          1: drive_max = '1;
          2: drive_max = 32'd1;
          3: drive_max = '0;
          4: drive_max = $urandom_range(2, 1000);
          5: drive_max = $urandom;
          default: drive_max = MAX_WEIGHT_RST;
        endcase
        write_max_weight(drive_max);
      end

      case (p)
        0: begin gap_max = 3; stall_max = 6;  end
        1: begin gap_max = 0; stall_max = 0;  end  // flat out both sides
        2: begin gap_max = 8; stall_max = 24; end
        3: begin gap_max = 2; stall_max = 3;  end
        4: begin gap_max = 5; stall_max = 12; end
        5: begin gap_max = 0; stall_max = 16; end
        default: begin gap_max = 6; stall_max = 0; end
      endcase

      sent = 0;
      seqs = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: a lone request of either kind with any content
          r.kind         = 1'($urandom);
          r.weight       = $urandom;
          r.available    = 1'($urandom);
          r.random_value = $urandom;
          push_request(r, 1'b0, '0);
          sent++;
        end else begin
          // a list of appends closed by a select; odd phases open with a near-full or overfull list
          if (seqs == 0 && (p % 2) == 1) begin
            seq_len = $urandom_range(63, 70);
          end else begin
            case ($urandom_range(0, 39))
              0:             seq_len = $urandom_range(60, 70);
              1, 2, 3, 4, 5: seq_len = $urandom_range(9, 30);
              6, 7:          seq_len = 0;
              default:       seq_len = $urandom_range(1, 8);
            endcase
          end
          for (k = 0; k < seq_len; k++) begin
            push_request(append_req(draw_weight(drive_max), $urandom_range(0, 4) != 0),
                         1'b0, '0);
          end
          // phase may end on appends, so the next select meets a new max weight
          if (sent + seq_len < ITEMS_PER_PHASE || $urandom_range(0, 1) == 0) begin
            push_request(select_req($urandom), 1'b0, '0);
            sent++;
          end
          sent += seq_len;
          seqs++;
        end
      end
    end

    in_valid <= 1'b0;
    wait_for_picks();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_picks.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/wrs_pkg.sv
hdl/wrs_store.sv
hdl/wrs_mod.sv
hdl/weighted_random_index_select.sv
verif/weighted_random_index_select_tb.sv
